@@ hw/rtl/acr_pkg.sv @@
package acr_pkg;

  // Coordinate format: signed fixed point, four fraction bits by default.
  // Only adds and compares are used, so the fraction position never matters.
  localparam int COORD_WIDTH = 20;
  localparam int SIZE_WIDTH  = COORD_WIDTH - 1;

  // Internal width: room for 2*position + size and for differences of sums.
  localparam int EXT_WIDTH = COORD_WIDTH + 3;

  localparam logic signed [EXT_WIDTH-1:0] COORD_MAX =
    EXT_WIDTH'((64'd1 << (COORD_WIDTH - 1)) - 64'd1);
  localparam logic signed [EXT_WIDTH-1:0] COORD_MIN = ~COORD_MAX;

  typedef enum logic [2:0] {
    MODE_OVERLAP      = 3'd0,
    MODE_OUTSIDE      = 3'd1,
    MODE_POINT_IN     = 3'd2,
    MODE_PUSH_OUT_BOX = 3'd3,
    MODE_PUSH_OUT_PT  = 3'd4,
    MODE_PUSH_IN_BOX  = 3'd5,
    MODE_PUSH_IN_PT   = 3'd6
  } mode_e;

  typedef struct packed {
    logic [2:0]                    mode;
    logic signed [COORD_WIDTH-1:0] host_x;
    logic signed [COORD_WIDTH-1:0] host_y;
    logic [SIZE_WIDTH-1:0]         host_w;
    logic [SIZE_WIDTH-1:0]         host_h;
    logic signed [COORD_WIDTH-1:0] other_x;
    logic signed [COORD_WIDTH-1:0] other_y;
    logic [SIZE_WIDTH-1:0]         other_w;
    logic [SIZE_WIDTH-1:0]         other_h;
  } query_t;

  typedef struct packed {
    logic                          hit;
    logic signed [COORD_WIDTH-1:0] new_x;
    logic signed [COORD_WIDTH-1:0] new_y;
    logic                          saturated;
  } result_t;

endpackage

@@ hw/rtl/aabb_collision_resolver_unit.sv @@
// Axis-aligned box collision resolver.
// Input channel: in_valid_i / in_stall_o carry one query beat (mode, host box,
// other box or point). Output channel: out_valid_o / out_stall_i carry one
// result beat (hit flag, adjusted position, saturation flag). A beat moves at
// a rising edge where valid is high and stall is low.
// Every query gives exactly one result, in order. The accepting edge loads
// the input register; the result register then loads the result through the
// geometry logic and shows it on the outputs. Throughput is one query per
// cycle while the receiver does not stall; the geometry is adds and compares
// only, and the path between the two registers sets the clock rate.
// When the receiver stalls, the result register holds its beat unchanged and
// the input register can still take one more query; in_stall_o rises only
// once both registers are full and the output is stalled.
// Reset clears both valid flags; no result is shown until a query arrives.
// There is no configuration and no state carried from one query to the next.
module aabb_collision_resolver_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  acr_pkg::query_t  in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output acr_pkg::result_t out_data_o
);

  // Input register.
  logic             in_valid_q, in_valid_d;
  acr_pkg::query_t  in_data_q;

  // Result register.
  logic             out_valid_q, out_valid_d;
  acr_pkg::result_t out_data_q;

  acr_pkg::result_t result;
  logic             out_ready;
  logic             in_ready;

  // The result register can load when it is empty or its beat leaves now.
  assign out_ready = !out_valid_q || !out_stall_i;
  // The input register can load when it is empty or its query moves on now.
  assign in_ready  = !in_valid_q || out_ready;

  assign in_valid_d  = in_ready ? in_valid_i : in_valid_q;
  assign out_valid_d = out_ready ? in_valid_q : out_valid_q;

  acr_resolve u_resolve (
    .query_i  (in_data_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers load only when a beat actually enters them.
  always_ff @(posedge clk_i) begin
    if (in_ready && in_valid_i) begin
      in_data_q <= in_data_i;
    end
    if (out_ready && in_valid_q) begin
      out_data_q <= result;
    end
  end

  assign in_stall_o  = !in_ready;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

@@ hw/rtl/acr_resolve.sv @@
// Combinational geometry for one query: tests, push-out and clamp moves,
// then saturation of the moved position back to the coordinate range.
module acr_resolve (
  input  acr_pkg::query_t  query_i,
  output acr_pkg::result_t result_o
);

  localparam int EW = acr_pkg::EXT_WIDTH;
  localparam int CW = acr_pkg::COORD_WIDTH;
  localparam int SW = acr_pkg::SIZE_WIDTH;

  logic signed [EW-1:0] hx, hy, hw, hh, ox, oy, ow, oh;
  logic signed [EW-1:0] h_right, h_bottom, o_right, o_bottom;
  logic signed [EW-1:0] dx, dy, abs_dx, abs_dy;
  logic signed [EW-1:0] nx, ny;
  logic                 overlap, outside, pin, hit;
  logic                 clip_x, clip_y;

  always_comb begin
    hx = {{(EW - CW){query_i.host_x[CW-1]}}, query_i.host_x};
    hy = {{(EW - CW){query_i.host_y[CW-1]}}, query_i.host_y};
    ox = {{(EW - CW){query_i.other_x[CW-1]}}, query_i.other_x};
    oy = {{(EW - CW){query_i.other_y[CW-1]}}, query_i.other_y};
    hw = {{(EW - SW){1'b0}}, query_i.host_w};
    hh = {{(EW - SW){1'b0}}, query_i.host_h};
    ow = {{(EW - SW){1'b0}}, query_i.other_w};
    oh = {{(EW - SW){1'b0}}, query_i.other_h};

    h_right  = hx + hw;
    h_bottom = hy + hh;
    o_right  = ox + ow;
    o_bottom = oy + oh;

    overlap = (h_right > ox) && (h_bottom > oy) && (hx < o_right) && (hy < o_bottom);
    outside = (hx < ox) || (hy < oy) || (h_right > o_right) || (h_bottom > o_bottom);
    pin     = (ox > hx) && (ox < h_right) && (oy > hy) && (oy < h_bottom);

    // Penetration depths, signed by the side of the other box's center.
    // Centers are compared doubled so nothing is halved.
    if (((ox <<< 1) + ow) <= ((hx <<< 1) + hw)) begin
      dx = o_right - hx;
    end else begin
      dx = ox - h_right;
    end
    if (((oy <<< 1) + oh) <= ((hy <<< 1) + hh)) begin
      dy = o_bottom - hy;
    end else begin
      dy = oy - h_bottom;
    end
    abs_dx = dx[EW-1] ? -dx : dx;
    abs_dy = dy[EW-1] ? -dy : dy;

    hit = 1'b0;
    nx  = ox;
    ny  = oy;
    case (acr_pkg::mode_e'(query_i.mode))
      acr_pkg::MODE_OVERLAP:  hit = overlap;
      acr_pkg::MODE_OUTSIDE:  hit = outside;
      acr_pkg::MODE_POINT_IN: hit = pin;
      acr_pkg::MODE_PUSH_OUT_BOX: begin
        hit = overlap;
        if (overlap) begin
          if (abs_dx > abs_dy) begin
            ny = oy - dy;
          end else begin
            nx = ox - dx;
          end
        end
      end
      acr_pkg::MODE_PUSH_OUT_PT: begin
        hit = pin;
        if (pin) begin
          nx = ((ox <<< 1) < ((hx <<< 1) + hw)) ? hx : h_right;
          ny = ((oy <<< 1) < ((hy <<< 1) + hh)) ? hy : h_bottom;
        end
      end
      acr_pkg::MODE_PUSH_IN_BOX: begin
        hit = outside;
        if (ox < hx) begin
          nx = hx;
        end else if (o_right > h_right) begin
          nx = h_right - ow;
        end
        if (oy < hy) begin
          ny = hy;
        end else if (o_bottom > h_bottom) begin
          ny = h_bottom - oh;
        end
      end
      acr_pkg::MODE_PUSH_IN_PT: begin
        hit = !pin;
        if (ox < hx) begin
          nx = hx;
        end else if (ox > h_right) begin
          nx = h_right;
        end
        if (oy < hy) begin
          ny = hy;
        end else if (oy > h_bottom) begin
          ny = h_bottom;
        end
      end
      default: hit = 1'b0;
    endcase

    clip_x = (nx > acr_pkg::COORD_MAX) || (nx < acr_pkg::COORD_MIN);
    clip_y = (ny > acr_pkg::COORD_MAX) || (ny < acr_pkg::COORD_MIN);

    result_o.hit = hit;
    if (nx > acr_pkg::COORD_MAX) begin
      result_o.new_x = acr_pkg::COORD_MAX[CW-1:0];
    end else if (nx < acr_pkg::COORD_MIN) begin
      result_o.new_x = acr_pkg::COORD_MIN[CW-1:0];
    end else begin
      result_o.new_x = nx[CW-1:0];
    end
    if (ny > acr_pkg::COORD_MAX) begin
      result_o.new_y = acr_pkg::COORD_MAX[CW-1:0];
    end else if (ny < acr_pkg::COORD_MIN) begin
      result_o.new_y = acr_pkg::COORD_MIN[CW-1:0];
    end else begin
      result_o.new_y = ny[CW-1:0];
    end
    result_o.saturated = clip_x || clip_y;
  end

endmodule

@@ hw/rtl/acr_checker.sv @@
module acr_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input acr_pkg::result_t out_data_o
);

  localparam int CW = acr_pkg::COORD_WIDTH;

  // A stalled result beat stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // A saturated result sits on a range limit in at least one coordinate.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.saturated |->
      (out_data_o.new_x == acr_pkg::COORD_MAX[CW-1:0]) ||
      (out_data_o.new_x == acr_pkg::COORD_MIN[CW-1:0]) ||
      (out_data_o.new_y == acr_pkg::COORD_MAX[CW-1:0]) ||
      (out_data_o.new_y == acr_pkg::COORD_MIN[CW-1:0]))
    else $error("saturation flag without a clipped coordinate");

  // The input side pushes back only when a result is waiting and stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while the output could drain");

  // An accepted query in the input register leads to a result beat once the output stall is low.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o ##1 !out_stall_i |=> out_valid_o)
    else $error("accepted query produced no result");

endmodule

bind aabb_collision_resolver_unit acr_checker u_acr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

@@ tb/aabb_collision_checker.sv @@
module aabb_collision_checker
  import acr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  query_t      in_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  result_t     out_data_i,
  output int unsigned mismatch_count_o,
  output int unsigned pending_count_o,
  output int unsigned checked_count_o,
  output int unsigned hit_count_o,
  output int unsigned clipped_count_o
);

  localparam longint COORD_HI = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
  localparam longint COORD_LO = -COORD_HI - 1;
  localparam int     REPORT_LIMIT = 40;

  result_t     expected_resolutions[$];
  result_t     oldest;
  int unsigned mismatches;
  int unsigned checked;
  int unsigned hits;
  int unsigned clipped;

  function automatic longint saturate(input longint v, inout logic clip);
    if (v > COORD_HI) begin
      clip = 1'b1;
      return COORD_HI;
    end
    if (v < COORD_LO) begin
      clip = 1'b1;
      return COORD_LO;
    end
    return v;
  endfunction

  // Works out the result of one query with wide integers, so no sum of two
  // coordinates can wrap before saturation.
  function automatic result_t resolve_query(input query_t q);
    longint  hx, hy, hw, hh, ox, oy, ow, oh, nx, ny, dx, dy;
    logic    overlap, outside, pt_in, clip;
    result_t r;
    hx = longint'($signed(q.host_x));
    hy = longint'($signed(q.host_y));
    hw = longint'(q.host_w);
    hh = longint'(q.host_h);
    ox = longint'($signed(q.other_x));
    oy = longint'($signed(q.other_y));
    ow = longint'(q.other_w);
    oh = longint'(q.other_h);
    nx = ox;
    ny = oy;
    clip = 1'b0;
    overlap = (hx + hw > ox) && (hy + hh > oy) && (hx < ox + ow) && (hy < oy + oh);
    outside = (hx < ox) || (hy < oy) || (hx + hw > ox + ow) || (hy + hh > oy + oh);
    pt_in = (ox > hx) && (ox < hx + hw) && (oy > hy) && (oy < hy + hh);
    r.hit = 1'b0;
    case (q.mode)
      MODE_OVERLAP:  r.hit = overlap;
      MODE_OUTSIDE:  r.hit = outside;
      MODE_POINT_IN: r.hit = pt_in;
      MODE_PUSH_OUT_BOX: begin
        r.hit = overlap;
        if (overlap) begin
          // Centers compared doubled; an exact tie counts as the low side.
          dx = (2 * ox + ow <= 2 * hx + hw) ? ox + ow - hx : ox - hx - hw;
          dy = (2 * oy + oh <= 2 * hy + hh) ? oy + oh - hy : oy - hy - hh;
          if ((dx < 0 ? -dx : dx) > (dy < 0 ? -dy : dy)) ny = oy - dy;
          else nx = ox - dx;
        end
      end
      MODE_PUSH_OUT_PT: begin
        r.hit = pt_in;
        if (pt_in) begin
          nx = (2 * ox < 2 * hx + hw) ? hx : hx + hw;
          ny = (2 * oy < 2 * hy + hh) ? hy : hy + hh;
        end
      end
      MODE_PUSH_IN_BOX: begin
        r.hit = outside;
        if (ox < hx) nx = hx;
        else if (ox + ow > hx + hw) nx = hx + hw - ow;
        if (oy < hy) ny = hy;
        else if (oy + oh > hy + hh) ny = hy + hh - oh;
      end
      MODE_PUSH_IN_PT: begin
        r.hit = !pt_in;
        if (ox < hx) nx = hx;
        else if (ox > hx + hw) nx = hx + hw;
        if (oy < hy) ny = hy;
        else if (oy > hy + hh) ny = hy + hh;
      end
      default: ;
    endcase
    nx = saturate(nx, clip);
    ny = saturate(ny, clip);
    r.new_x = nx[COORD_WIDTH-1:0];
    r.new_y = ny[COORD_WIDTH-1:0];
    r.saturated = clip;
    return r;
  endfunction

  task automatic report_field(input string field,
                              input logic signed [COORD_WIDTH-1:0] want,
                              input logic signed [COORD_WIDTH-1:0] got);
    if (mismatches < REPORT_LIMIT) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    end
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_resolutions.size() == 0) begin
          if (mismatches < REPORT_LIMIT) begin
            $display("%0t: result beat with nothing expected, expected none, got %p",
                     $time, out_data_i);
          end
          mismatches++;
        end else begin
          oldest = expected_resolutions.pop_front();
          if (out_data_i.hit !== oldest.hit)
            report_field("hit", oldest.hit, out_data_i.hit);
          if (out_data_i.new_x !== oldest.new_x)
            report_field("new_x", oldest.new_x, out_data_i.new_x);
          if (out_data_i.new_y !== oldest.new_y)
            report_field("new_y", oldest.new_y, out_data_i.new_y);
          if (out_data_i.saturated !== oldest.saturated)
            report_field("saturated", oldest.saturated, out_data_i.saturated);
          checked++;
          if (oldest.hit) hits++;
          if (oldest.saturated) clipped++;
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_resolutions.push_back(resolve_query(in_data_i));
      end
    end
    mismatch_count_o <= mismatches;
    pending_count_o  <= expected_resolutions.size();
    checked_count_o  <= checked;
    hit_count_o      <= hits;
    clipped_count_o  <= clipped;
  end

endmodule

@@ tb/aabb_collision_resolver_unit_test.sv @@
// Test bench top for the box collision resolver. It drives query beats into
// the block, toggles the result stall, and leaves all prediction and
// comparison to the checker module that watches both channels beside it.
module aabb_collision_resolver_unit_test;
  import acr_pkg::*;

  localparam int HALF_PERIOD  = 2;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES  = 60;
  localparam int C_MAX        = (1 << (COORD_WIDTH - 1)) - 1;
  localparam int C_MIN        = -C_MAX - 1;
  localparam int S_MAX        = (1 << SIZE_WIDTH) - 1;

  // The mode field is three bits wide but only seven codes are defined; the
  // eighth must act as a plain pass-through with no hit.
  localparam logic [2:0] MODE_UNUSED = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  query_t      in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  result_t     out_data;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned checked;
  int unsigned hits;
  int unsigned clipped;

  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  logic        hold_request = 1'b0;
  int          cycle_count = 0;

  aabb_collision_resolver_unit DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  aabb_collision_checker u_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_data_i       (out_data),
    .mismatch_count_o (mismatches),
    .pending_count_o  (pending),
    .checked_count_o  (checked),
    .hit_count_o      (hits),
    .clipped_count_o  (clipped)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // Offers one query beat. A random run of idle cycles may come first; the
  // task returns at the edge where the beat is taken, with valid still high,
  // so back-to-back beats keep valid up without a glitch.
  task automatic send_query(input query_t q);
    if ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99, 0) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= q;
    do @(posedge clk); while (in_stall);
  endtask

  // Builds a query from plain integers; coordinates wrap to the port width.
  task automatic offer(input logic [2:0] mode, input int hx, input int hy,
                       input int hw, input int hh, input int ox, input int oy,
                       input int ow, input int oh);
    query_t q;
    q.mode    = mode;
    q.host_x  = hx[COORD_WIDTH-1:0];
    q.host_y  = hy[COORD_WIDTH-1:0];
    q.host_w  = hw[SIZE_WIDTH-1:0];
    q.host_h  = hh[SIZE_WIDTH-1:0];
    q.other_x = ox[COORD_WIDTH-1:0];
    q.other_y = oy[COORD_WIDTH-1:0];
    q.other_w = ow[SIZE_WIDTH-1:0];
    q.other_h = oh[SIZE_WIDTH-1:0];
    send_query(q);
  endtask

  // The sender stops and waits until every predicted result has come back.
  // One edge passes first so the checker has counted the last beat taken.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic int near_limit_coord();
    if ($urandom_range(1, 0)) return C_MAX - int'($urandom_range(2048, 0));
    return C_MIN + int'($urandom_range(2048, 0));
  endfunction

  // Most random queries place the other box or point around the host so that
  // overlaps, containment, pushes and clamps all occur. Tight ones use tiny
  // sizes so that center ties and equal depths come up; queries near the ends
  // of the coordinate range drive the saturation paths; a tenth are raw bits.
  function automatic query_t random_query();
    query_t       q;
    logic [159:0] raw;
    int           kind, span, hx, hy, ox, oy;
    kind = $urandom_range(99, 0);
    if (kind < 10) begin
      raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
      return raw[$bits(query_t)-1:0];
    end
    span = (kind < 40) ? 16 : 4096;
    if (kind >= 75) begin
      hx = near_limit_coord();
      hy = near_limit_coord();
    end else begin
      hx = int'($urandom_range(16384, 0)) - 8192;
      hy = int'($urandom_range(16384, 0)) - 8192;
    end
    ox = hx - span + int'($urandom_range(3 * span, 0));
    oy = hy - span + int'($urandom_range(3 * span, 0));
    q.mode    = ($urandom_range(49, 0) == 0) ? MODE_UNUSED : 3'($urandom_range(6, 0));
    q.host_x  = hx[COORD_WIDTH-1:0];
    q.host_y  = hy[COORD_WIDTH-1:0];
    q.host_w  = SIZE_WIDTH'($urandom_range(span, 0));
    q.host_h  = SIZE_WIDTH'($urandom_range(span, 0));
    q.other_x = ox[COORD_WIDTH-1:0];
    q.other_y = oy[COORD_WIDTH-1:0];
    q.other_w = SIZE_WIDTH'($urandom_range(span, 0));
    q.other_h = SIZE_WIDTH'($urandom_range(span, 0));
    return q;
  endfunction

  task automatic run_phase(input int count, input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (count) send_query(random_query());
    wait_for_results();
  endtask

  // Result side. Normally the stall is drawn fresh every cycle; on request it
  // is held high for a long stretch so the block backs up and stalls its input.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99, 0) < recv_idle_pct);
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed queries: field extremes, every mode, and the corner cases.
    send_idle_pct = 20;
    recv_idle_pct = 20;
    // Overlap: plain hit, edges that only touch, and boxes spanning the range.
    offer(MODE_OVERLAP, 0, 0, 100, 100, 50, 50, 100, 100);
    offer(MODE_OVERLAP, 0, 0, 100, 100, 100, 0, 10, 10);
    offer(MODE_OVERLAP, C_MIN, C_MIN, S_MAX, S_MAX, C_MAX, C_MAX, S_MAX, S_MAX);
    // Outside: host fully contained, then host sticking out.
    offer(MODE_OUTSIDE, 10, 10, 10, 10, 0, 0, 100, 100);
    offer(MODE_OUTSIDE, 0, 0, 100, 100, 20, 20, 5, 5);
    // Point inside: strictly inside, on the left edge, zero-size host.
    offer(MODE_POINT_IN, 0, 0, 100, 100, 50, 50, 0, 0);
    offer(MODE_POINT_IN, 0, 0, 100, 100, 0, 50, S_MAX, S_MAX);
    offer(MODE_POINT_IN, C_MAX, C_MAX, 0, 0, C_MAX, C_MAX, 0, 0);
    // Box push-out: along x, along y, equal centers with equal depths (moves
    // along x from the low side), a flat host where the y depth must come from
    // the heights, no overlap at all, and a push past the top of the range.
    offer(MODE_PUSH_OUT_BOX, 0, 0, 100, 100, 90, 10, 20, 80);
    offer(MODE_PUSH_OUT_BOX, 0, 0, 100, 100, 10, 90, 80, 20);
    offer(MODE_PUSH_OUT_BOX, 0, 0, 100, 100, 40, 40, 20, 20);
    offer(MODE_PUSH_OUT_BOX, 0, 0, 100, 50, 10, 40, 80, 30);
    offer(MODE_PUSH_OUT_BOX, 0, 0, 10, 10, 50, 50, 5, 5);
    offer(MODE_PUSH_OUT_BOX, C_MAX - 200, 0, 210, 1000, C_MAX - 5, 0, 4, 1000);
    // Point push-out: toward the low edges, from the exact center (goes to the
    // high edges), from outside (no move), and onto an edge beyond the range.
    offer(MODE_PUSH_OUT_PT, 0, 0, 100, 100, 10, 20, 0, 0);
    offer(MODE_PUSH_OUT_PT, 0, 0, 100, 100, 50, 50, 0, 0);
    offer(MODE_PUSH_OUT_PT, 0, 0, 100, 100, 150, 50, 0, 0);
    offer(MODE_PUSH_OUT_PT, C_MAX - 100, 0, 150, 100, C_MAX - 10, 50, 0, 0);
    // Box clamp: against the low edges, the high edges, an other box wider
    // than the host, and a clamp that falls below the range on both axes.
    offer(MODE_PUSH_IN_BOX, 0, 0, 100, 100, -30, -30, 20, 20);
    offer(MODE_PUSH_IN_BOX, 0, 0, 100, 100, 90, 95, 20, 20);
    offer(MODE_PUSH_IN_BOX, 0, 0, 10, 10, 5, 5, 30, 30);
    offer(MODE_PUSH_IN_BOX, C_MIN, C_MIN, 0, 0, C_MIN, C_MIN, S_MAX, S_MAX);
    // Point clamp: from outside on two sides, and from inside (no move).
    offer(MODE_PUSH_IN_PT, 0, 0, 100, 100, 200, -50, 0, 0);
    offer(MODE_PUSH_IN_PT, 0, 0, 100, 100, 50, 50, 0, 0);
    // The undefined mode code.
    offer(MODE_UNUSED, 0, 0, 100, 100, 50, 50, 10, 10);
    wait_for_results();

    // Back-pressure: the result side holds its stall for a long stretch while
    // beats keep coming with no gaps, so both internal registers fill and the
    // input stall must rise. Then the sender waits for the pipe to empty.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request = 1'b1;
    repeat (16) send_query(random_query());
    wait_for_results();

    // Random traffic under three idle mixes: slow receiver, slow sender, and
    // both sides running flat out.
    run_phase(145, 17, 83);
    run_phase(145, 83, 17);
    run_phase(145, 0, 0);

    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Compared %0d result beats (%0d hits, %0d clipped) across all eight mode codes.",
             checked, hits, clipped);
    $display("Traffic ran with both sides idling in turn, back to back, and behind a long hold.");
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ aabb_collision_resolver_unit.f @@
hw/rtl/acr_pkg.sv
hw/rtl/acr_resolve.sv
hw/rtl/aabb_collision_resolver_unit.sv
hw/rtl/acr_checker.sv
tb/aabb_collision_checker.sv
tb/aabb_collision_resolver_unit_test.sv
